// ===== rtl/nst_pkg.sv =====
`timescale 1ns / 1ps

package nst_pkg;

   // Table geometry
   localparam int TABLE_SLOTS  = 16;
   localparam int NAME_BYTES   = 8;
   localparam int SLOT_W       = 4;
   localparam int NAME_KEY_W   = 64;
   localparam int COUNT_W      = 16;
   localparam int STATUS_W     = 3;
   localparam int USABLE_SLOTS = (TABLE_SLOTS < (1 << SLOT_W)) ? TABLE_SLOTS : (1 << SLOT_W);
   localparam int SLOT_AW      = (USABLE_SLOTS > 1) ? $clog2(USABLE_SLOTS) : 1;
   localparam int SLOT_CW      = $clog2(USABLE_SLOTS + 1);
   localparam int NAME_W       = 8 * NAME_BYTES;

   localparam logic signed [COUNT_W-1:0] COUNT_MIN = {1'b1, {(COUNT_W-1){1'b0}}};
   localparam logic signed [COUNT_W-1:0] COUNT_MAX = {1'b0, {(COUNT_W-1){1'b1}}};

   typedef enum logic [1:0] {
      REQ_OPEN    = 2'd0,
      REQ_DESTROY = 2'd1,
      REQ_PROCURE = 2'd2,
      REQ_VACATE  = 2'd3
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 3'd0,
      ST_EXISTS  = 3'd1,
      ST_UNKNOWN = 3'd2,
      ST_FULL    = 3'd3,
      ST_BLOCKED = 3'd4,
      ST_BAD     = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_OPEN_DONE,
      S_CNT_RD,
      S_CNT_UPD
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic scan_start;
      logic scan_step;
      logic open_commit;
      logic cnt_read;
      logic cnt_commit;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic out_free;
   } sts_type;

endpackage

// ===== rtl/named_semaphore_table_top.sv =====
`timescale 1ns / 1ps

// Channel    Handshake              Payload
// request    req_valid / req_stall  req_type, req_name_key, req_init_value, req_slot_index
// response   rsp_valid / rsp_stall  rsp_status, rsp_slot_out, rsp_must_wait, rsp_wake_one
//
// Open runs a name scan that reads one slot of the name RAM per cycle. Destroy,
// procure and vacate do one count RAM read, then the read-modify-write. One
// request is in work at a time.
// Reset clears the slot-used flags; name and count RAMs need no clearing.
// A stalled response holds in the output register; the next request is still
// accepted and finishes once the output register is free.

module named_semaphore_table_top
   import nst_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_type,
   input  logic [NAME_KEY_W-1:0]     req_name_key,
   input  logic signed [COUNT_W-1:0] req_init_value,
   input  logic [SLOT_W-1:0]         req_slot_index,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [SLOT_W-1:0]         rsp_slot_out,
   output logic                      rsp_must_wait,
   output logic                      rsp_wake_one
);

   cmd_type cmd;
   sts_type sts;

   nst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   nst_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_type       (req_type),
      .req_name_key   (req_name_key),
      .req_init_value (req_init_value),
      .req_slot_index (req_slot_index),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_slot_out   (rsp_slot_out),
      .rsp_must_wait  (rsp_must_wait),
      .rsp_wake_one   (rsp_wake_one)
   );

endmodule

// ===== rtl/nst_ram.sv =====
`timescale 1ns / 1ps

module nst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/nst_ctrl.sv =====
`timescale 1ns / 1ps

module nst_ctrl
   import nst_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_type,
   output logic       req_stall,
   output cmd_type    cmd,
   input  sts_type    sts
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = reset;
            if (req_valid && !reset) begin
               cmd.load       = 1'b1;
               cmd.scan_start = 1'b1;
               state_in       = (req_type == REQ_OPEN) ? S_SCAN : S_CNT_RD;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) begin
               state_in = S_OPEN_DONE;
            end
         end
         S_OPEN_DONE: begin
            // hold until the output register can take the result
            if (sts.out_free) begin
               cmd.open_commit = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_CNT_RD: begin
            cmd.cnt_read = 1'b1;
            state_in     = S_CNT_UPD;
         end
         S_CNT_UPD: begin
            if (sts.out_free) begin
               cmd.cnt_commit = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/nst_dp.sv =====
`timescale 1ns / 1ps

module nst_dp
   import nst_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic [1:0]                 req_type,
   input  logic [NAME_KEY_W-1:0]      req_name_key,
   input  logic signed [COUNT_W-1:0]  req_init_value,
   input  logic [SLOT_W-1:0]          req_slot_index,
   input  cmd_type                    cmd,
   output sts_type                    sts,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [SLOT_W-1:0]          rsp_slot_out,
   output logic                       rsp_must_wait,
   output logic                       rsp_wake_one
);

   // request registers
   req_kind_type              op_ff;
   logic [NAME_W-1:0]         key_ff;
   logic signed [COUNT_W-1:0] val_ff;
   logic [SLOT_W-1:0]         slot_ff;

   logic [USABLE_SLOTS-1:0]   used_ff, used_in;

   // scan state
   logic [SLOT_CW-1:0]        scan_ff, scan_in;
   logic                      pend_vld_ff, pend_vld_in;
   logic [SLOT_AW-1:0]        pend_ix_ff, pend_ix_in;
   logic                      hit_ff, hit_in;
   logic [SLOT_AW-1:0]        hit_ix_ff, hit_ix_in;
   logic                      free_ff, free_in;
   logic [SLOT_AW-1:0]        free_ix_ff, free_ix_in;

   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]       rsp_status_ff;
   logic [SLOT_W-1:0]         rsp_slot_ff;
   logic                      rsp_wait_ff;
   logic                      rsp_wake_ff;

   logic                      issue;
   logic [NAME_W-1:0]         name_rdata;
   logic [COUNT_W-1:0]        cnt_rdata;
   logic signed [COUNT_W-1:0] cnt;
   logic                      slot_ok;
   logic [SLOT_AW-1:0]        slot_ix;

   logic                      name_we;
   logic                      cnt_we;
   logic [SLOT_AW-1:0]        cnt_waddr;
   logic [COUNT_W-1:0]        cnt_wdata;
   status_type                res_status;
   logic [SLOT_W-1:0]         res_slot;
   logic                      res_wait;
   logic                      res_wake;
   logic                      commit;

   assign issue   = cmd.scan_step && (scan_ff < SLOT_CW'(USABLE_SLOTS));
   assign slot_ix = slot_ff[SLOT_AW-1:0];
   assign slot_ok = ({1'b0, slot_ff} < (SLOT_W+1)'(USABLE_SLOTS)) && used_ff[slot_ix];
   assign cnt     = $signed(cnt_rdata);
   assign commit  = cmd.open_commit || cmd.cnt_commit;

   nst_ram #(.WIDTH(NAME_W), .DEPTH(USABLE_SLOTS)) u_name_ram (
      .clock   (clock),
      .wr_en   (name_we),
      .wr_addr (free_ix_ff),
      .wr_data (key_ff),
      .rd_en   (issue),
      .rd_addr (scan_ff[SLOT_AW-1:0]),
      .rd_data (name_rdata)
   );

   nst_ram #(.WIDTH(COUNT_W), .DEPTH(USABLE_SLOTS)) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_en   (cmd.cnt_read),
      .rd_addr (slot_ix),
      .rd_data (cnt_rdata)
   );

   // scan: one name read a cycle, compared in the cycle after
   always_comb begin
      scan_in     = scan_ff;
      pend_vld_in = pend_vld_ff;
      pend_ix_in  = pend_ix_ff;
      hit_in      = hit_ff;
      hit_ix_in   = hit_ix_ff;
      free_in     = free_ff;
      free_ix_in  = free_ix_ff;
      if (cmd.scan_start) begin
         scan_in     = '0;
         pend_vld_in = 1'b0;
         hit_in      = 1'b0;
         free_in     = 1'b0;
      end else if (cmd.scan_step) begin
         pend_vld_in = issue;
         pend_ix_in  = scan_ff[SLOT_AW-1:0];
         if (issue) begin
            scan_in = scan_ff + 1'b1;
         end
         if (pend_vld_ff) begin
            if (used_ff[pend_ix_ff] && (name_rdata == key_ff) && !hit_ff) begin
               hit_in    = 1'b1;
               hit_ix_in = pend_ix_ff;
            end
            if (!used_ff[pend_ix_ff] && !free_ff) begin
               free_in    = 1'b1;
               free_ix_in = pend_ix_ff;
            end
         end
      end
   end

   assign sts.scan_done = pend_vld_ff && (pend_ix_ff == SLOT_AW'(USABLE_SLOTS - 1));
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   // result and table update
   always_comb begin
      used_in    = used_ff;
      name_we    = 1'b0;
      cnt_we     = 1'b0;
      cnt_waddr  = slot_ix;
      cnt_wdata  = cnt_rdata;
      res_status = ST_OK;
      res_slot   = '0;
      res_wait   = 1'b0;
      res_wake   = 1'b0;
      if (cmd.open_commit) begin
         if (!val_ff[COUNT_W-1]) begin
            if (hit_ff) begin
               res_status = ST_EXISTS;
            end else if (!free_ff) begin
               res_status = ST_FULL;
            end else begin
               name_we             = 1'b1;
               cnt_we              = 1'b1;
               cnt_waddr           = free_ix_ff;
               cnt_wdata           = val_ff;
               used_in[free_ix_ff] = 1'b1;
               res_slot            = SLOT_W'(free_ix_ff);
            end
         end else if (hit_ff) begin
            res_slot = SLOT_W'(hit_ix_ff);
         end else begin
            res_status = ST_UNKNOWN;
         end
      end else if (cmd.cnt_commit) begin
         if (!slot_ok) begin
            res_status = ST_BAD;
         end else begin
            unique case (op_ff)
               REQ_DESTROY: begin
                  if (cnt < 0) begin
                     res_status = ST_BLOCKED;
                  end else begin
                     used_in[slot_ix] = 1'b0;
                  end
               end
               REQ_PROCURE: begin
                  if (cnt == COUNT_MIN) begin
                     res_status = ST_BAD;
                  end else begin
                     cnt_we    = 1'b1;
                     cnt_wdata = cnt - 16'sd1;
                     res_wait  = (cnt <= 0);
                  end
               end
               REQ_VACATE: begin
                  if (cnt == COUNT_MAX) begin
                     res_status = ST_BAD;
                  end else begin
                     cnt_we    = 1'b1;
                     cnt_wdata = cnt + 16'sd1;
                     res_wake  = (cnt < 0);
                  end
               end
               REQ_OPEN: begin
                  res_status = ST_OK;
               end
               default: begin
                  res_status = ST_OK;
               end
            endcase
         end
      end
   end

   assign rsp_valid_in = commit ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         scan_ff      <= '0;
         pend_vld_ff  <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         scan_ff      <= scan_in;
         pend_vld_ff  <= pend_vld_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ix_ff <= pend_ix_in;
      hit_ix_ff  <= hit_ix_in;
      free_ix_ff <= free_ix_in;
      if (cmd.load) begin
         op_ff   <= req_kind_type'(req_type);
         key_ff  <= req_name_key[NAME_W-1:0];
         val_ff  <= req_init_value;
         slot_ff <= req_slot_index;
      end
      if (commit) begin
         rsp_status_ff <= res_status;
         rsp_slot_ff   <= res_slot;
         rsp_wait_ff   <= res_wait;
         rsp_wake_ff   <= res_wake;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_slot_out  = rsp_slot_ff;
   assign rsp_must_wait = rsp_wait_ff;
   assign rsp_wake_one  = rsp_wake_ff;

endmodule
